@@ hw/rtl/pfac_pkg.sv @@
package pfac_pkg;

    localparam int HDR_MAX_BYTES = 5;
    localparam int HDR_BITS      = HDR_MAX_BYTES * 8;

    localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_TOP       = 16'h8000;
    localparam logic [7:0]  ASCII_DIGIT   = 8'h30;
    localparam logic [7:0]  ASCII_ALPHA   = 8'h37;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_POLY     = 2'd0;
    localparam logic [1:0] REG_PRE_CNT  = 2'd1;
    localparam logic [1:0] REG_HDR_VAL  = 2'd2;
    localparam logic [1:0] REG_HDR_LEN  = 2'd3;

    localparam logic [15:0]         POLY_RESET    = 16'h1021;
    localparam logic [3:0]          PRE_CNT_RESET = 4'd10;
    localparam logic [HDR_BITS-1:0] HDR_VAL_RESET = 40'h0102030405;
    localparam logic [2:0]          HDR_LEN_RESET = 3'd5;

    typedef struct packed {
        logic [15:0]         poly;
        logic [3:0]          pre_cnt;
        logic [HDR_BITS-1:0] hdr_val;
        logic [2:0]          hdr_len;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       run_last;
        logic       frame_end;
    } t_emit;

    // upper-case ascii hex character of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = {4'd0, nib};
        hex_char = (nib <= 4'd9) ? (v + ASCII_DIGIT) : (v + ASCII_ALPHA);
    endfunction

    // eight msb-first crc steps over one character
    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [7:0]  ch,
                                             input logic [15:0] poly);
        logic [15:0] r;
        logic [15:0] sh;
        logic        top;
        r  = crc;
        sh = {ch, 8'd0};
        for (int i = 0; i < 8; i++) begin
            top = ((r ^ sh) & CRC_TOP) != 16'd0;
            r   = {r[14:0], 1'b0};
            if (top) begin
                r = r ^ poly;
            end
            sh = {sh[14:0], 1'b0};
        end
        crc_fold = r;
    endfunction

    // header byte idx, first byte in the top bits
    function automatic logic [7:0] hdr_byte(input logic [HDR_BITS-1:0] val,
                                            input logic [2:0]          idx);
        logic [7:0] b;
        b = 8'd0;
        for (int i = 0; i < HDR_MAX_BYTES; i++) begin
            if (idx == 3'(i)) begin
                b = val[(HDR_MAX_BYTES-1-i)*8 +: 8];
            end
        end
        hdr_byte = b;
    endfunction

endpackage

@@ hw/rtl/packet_framer_ascii_crc16_unit.sv @@
// Radio frame builder. Payload bytes arrive on the slave stream with tlast on the final
// byte of a packet; the master stream carries the frame one byte per transaction: the
// preamble (preamble_count bytes of 0x55), an opening 0x7E flag, header_length header
// bytes (clamped to five, first byte from the top of header_value), the payload bytes
// as they came, the CRC-16 high and low bytes and two 0x7E flags. The CRC starts at
// 0xFFFF and runs msb first over the two upper-case ascii hex characters of every
// payload byte, not over the header. Master tlast marks the last frame byte caused by
// one input transaction and tuser marks the final closing flag. The sequencer sends one
// frame byte per cycle through the output register, stalling while the master side holds
// tready low. A payload byte in the middle of a packet is sent in the same cycle in which
// both of its hex characters are folded into the crc; the first byte of a packet comes
// after the preamble, the opening flag and the header, and the last byte is followed by
// the crc bytes and the two closing flags. The input register takes the
// next transaction in the cycle the current byte finishes. Registers sit on an APB
// port at byte addresses 0 (polynomial), 8 (preamble count), 16 (header value) and
// 24 (header length); write them only between transactions.
module packet_framer_ascii_crc16_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // payload in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    // frame out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] frame_byte
    output logic        o_m_axis_tlast,   // run_last
    output logic [0:0]  o_m_axis_tuser,   // [0] frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import pfac_pkg::*;

    t_cfg  cfg;
    t_emit emit;
    logic  emit_ok;
    logic  fend;

    // register file
    pfac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register, frame sequencer and crc
    pfac_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tlast  (i_s_axis_tlast),
        .o_emit     (emit),
        .i_emit_ok  (emit_ok)
    );

    // result register toward the master side
    pfac_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_emit     (emit),
        .o_emit_ok  (emit_ok),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (fend)
    );

    assign o_m_axis_tuser = fend;

    // the frame end always closes the run of its input
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && fend |-> o_m_axis_tlast)
        else $error("frame end without run end");

    // the frame end is the closing flag
    a_fend_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && fend |-> o_m_axis_tdata == FLAG_BYTE)
        else $error("frame end byte is not a flag");

    // a polynomial write lands in the register file
    a_poly_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[4:3] == REG_POLY |=> cfg.poly == $past(pwdata[15:0]))
        else $error("polynomial write lost");

endmodule

@@ hw/rtl/pfac_regs.sv @@
module pfac_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output pfac_pkg::t_cfg      o_cfg
);
    import pfac_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[4:3];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly    <= POLY_RESET;
            r_cfg.pre_cnt <= PRE_CNT_RESET;
            r_cfg.hdr_val <= HDR_VAL_RESET;
            r_cfg.hdr_len <= HDR_LEN_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_POLY:    r_cfg.poly    <= pwdata[15:0];
                REG_PRE_CNT: r_cfg.pre_cnt <= pwdata[3:0];
                REG_HDR_VAL: r_cfg.hdr_val <= pwdata[HDR_BITS-1:0];
                REG_HDR_LEN: r_cfg.hdr_len <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_POLY:    prdata = {48'd0, r_cfg.poly};
            REG_PRE_CNT: prdata = {60'd0, r_cfg.pre_cnt};
            REG_HDR_VAL: prdata = 64'(r_cfg.hdr_val);
            REG_HDR_LEN: prdata = {61'd0, r_cfg.hdr_len};
            default:     prdata = 64'd0;
        endcase
    end

endmodule

@@ hw/rtl/pfac_framer.sv @@
module pfac_framer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfac_pkg::t_cfg  i_cfg,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,
    input  logic            i_s_tlast,
    output pfac_pkg::t_emit o_emit,
    input  logic            i_emit_ok
);
    import pfac_pkg::*;

    localparam logic [3:0] PH_BEGIN = 4'd0;
    localparam logic [3:0] PH_PRE   = 4'd1;
    localparam logic [3:0] PH_FLAG  = 4'd2;
    localparam logic [3:0] PH_HDR   = 4'd3;
    localparam logic [3:0] PH_DATA  = 4'd4;
    localparam logic [3:0] PH_CRCH  = 4'd6;
    localparam logic [3:0] PH_CRCL  = 4'd7;
    localparam logic [3:0] PH_FL1   = 4'd8;
    localparam logic [3:0] PH_FL2   = 4'd9;

    logic        r_in_vld;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic        r_in_frame, n_in_frame;
    logic [3:0]  eff_phase;
    logic [2:0]  hl;
    logic        done;
    logic        accept;
    t_emit       emit;

    assign o_s_tready = !r_in_vld || done;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_emit     = emit;

    always_comb begin
        hl = ({1'b0, i_cfg.hdr_len} > 4'(HDR_MAX_BYTES)) ? 3'(HDR_MAX_BYTES) : i_cfg.hdr_len;
        if (r_phase == PH_BEGIN) begin
            if (r_in_frame) begin
                eff_phase = PH_DATA;
            end else if (i_cfg.pre_cnt != 4'd0) begin
                eff_phase = PH_PRE;
            end else begin
                eff_phase = PH_FLAG;
            end
        end else begin
            eff_phase = r_phase;
        end
    end

    always_comb begin
        emit       = '0;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_crc      = r_crc;
        n_in_frame = r_in_frame;
        done       = 1'b0;
        if (r_in_vld) begin
            unique case (eff_phase)
                PH_PRE: begin
                    emit.valid = 1'b1;
                    emit.data  = PREAMBLE_BYTE;
                    if (i_emit_ok) begin
                        if (r_cnt == 4'(i_cfg.pre_cnt - 4'd1)) begin
                            n_phase = PH_FLAG;
                            n_cnt   = 4'd0;
                        end else begin
                            n_phase = PH_PRE;
                            n_cnt   = r_cnt + 4'd1;
                        end
                    end
                end
                PH_FLAG: begin
                    emit.valid = 1'b1;
                    emit.data  = FLAG_BYTE;
                    if (i_emit_ok) begin
                        n_crc   = CRC_INIT;
                        n_cnt   = 4'd0;
                        n_phase = (hl != 3'd0) ? PH_HDR : PH_DATA;
                    end
                end
                PH_HDR: begin
                    emit.valid = 1'b1;
                    emit.data  = hdr_byte(i_cfg.hdr_val, r_cnt[2:0]);
                    if (i_emit_ok) begin
                        if (r_cnt[2:0] == 3'(hl - 3'd1)) begin
                            n_phase = PH_DATA;
                            n_cnt   = 4'd0;
                        end else begin
                            n_cnt   = r_cnt + 4'd1;
                        end
                    end
                end
                PH_DATA: begin
                    emit.valid    = 1'b1;
                    emit.data     = r_in_data;
                    emit.run_last = !r_in_last;
                    if (i_emit_ok) begin
                        // both hex characters, high nibble first
                        n_crc      = crc_fold(crc_fold(r_crc, hex_char(r_in_data[7:4]),
                                                       i_cfg.poly),
                                              hex_char(r_in_data[3:0]), i_cfg.poly);
                        n_in_frame = 1'b1;
                        if (r_in_last) begin
                            n_phase = PH_CRCH;
                        end else begin
                            n_phase = PH_BEGIN;
                            done    = 1'b1;
                        end
                    end
                end
                PH_CRCH: begin
                    emit.valid = 1'b1;
                    emit.data  = r_crc[15:8];
                    if (i_emit_ok) begin
                        n_phase = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    emit.valid = 1'b1;
                    emit.data  = r_crc[7:0];
                    if (i_emit_ok) begin
                        n_phase = PH_FL1;
                    end
                end
                PH_FL1: begin
                    emit.valid = 1'b1;
                    emit.data  = FLAG_BYTE;
                    if (i_emit_ok) begin
                        n_phase = PH_FL2;
                    end
                end
                PH_FL2: begin
                    emit.valid     = 1'b1;
                    emit.data      = FLAG_BYTE;
                    emit.run_last  = 1'b1;
                    emit.frame_end = 1'b1;
                    if (i_emit_ok) begin
                        n_in_frame = 1'b0;
                        n_crc      = CRC_INIT;
                        n_phase    = PH_BEGIN;
                        done       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_phase    <= PH_BEGIN;
            r_cnt      <= 4'd0;
            r_crc      <= CRC_INIT;
            r_in_frame <= 1'b0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (done) begin
                r_in_vld <= 1'b0;
            end
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_crc      <= n_crc;
            r_in_frame <= n_in_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

endmodule

@@ hw/rtl/pfac_outreg.sv @@
module pfac_outreg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfac_pkg::t_emit i_emit,
    output logic            o_emit_ok,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic            o_m_tlast,
    output logic            o_m_tuser
);
    import pfac_pkg::*;

    logic       r_vld;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_fend;

    assign o_emit_ok  = !r_vld || i_m_tready;
    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_emit_ok) begin
            r_vld <= i_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_emit_ok && i_emit.valid) begin
            r_data <= i_emit.data;
            r_last <= i_emit.run_last;
            r_fend <= i_emit.frame_end;
        end
    end

endmodule

@@ dv/tb_packet_framer_ascii_crc16_unit.sv @@
`timescale 1ns / 1ps

module tb_packet_framer_ascii_crc16_unit;
    import pfac_pkg::*;

    localparam int RANDOM_ITEMS = 460;
    localparam int CYCLE_LIMIT  = 4_000_000;
    // quiet cycles after the last frame byte before registers change
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int LONG_HOLD     = 400;

    // expected frame bytes, built by running the framer and crc on the side
    class t_frame_scoreboard;
        typedef struct {
            logic [7:0] frame_byte;
            logic       run_last;
            logic       frame_end;
        } t_frame_beat;

        logic [15:0]         poly;
        logic [3:0]          preamble_len;
        logic [HDR_BITS-1:0] hdr_value;
        logic [2:0]          header_len;
        bit                  in_frame;
        logic [15:0]         crc;
        t_frame_beat         expected_beats[$];
        int                  errors;

        function new();
            poly         = POLY_RESET;
            preamble_len = PRE_CNT_RESET;
            hdr_value    = HDR_VAL_RESET;
            header_len   = HDR_LEN_RESET;
            in_frame     = 1'b0;
            crc          = CRC_INIT;
            errors       = 0;
        endfunction

        // bits above each register width are dropped
        function void write_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_POLY:    poly = value[15:0];
                REG_PRE_CNT: preamble_len = value[3:0];
                REG_HDR_VAL: hdr_value = value[HDR_BITS-1:0];
                REG_HDR_LEN: header_len = value[2:0];
                default: ;
            endcase
        endfunction

        function void push_beat(logic [7:0] fb, logic fe);
            t_frame_beat beat;
            beat.frame_byte = fb;
            beat.run_last   = 1'b0;
            beat.frame_end  = fe;
            expected_beats.push_back(beat);
        endfunction

        function logic [7:0] ascii_hex(logic [3:0] nib);
            if (nib <= 4'd9) begin
                return 8'(nib) + ASCII_DIGIT;
            end else begin
                return 8'(nib) + ASCII_ALPHA;
            end
        endfunction

        // msb-first crc over one character, polynomial in force right now
        function void fold_char(logic [7:0] ch);
            logic [15:0] sh;
            logic        msb;
            sh = {ch, 8'h00};
            for (int k = 0; k < 8; k++) begin
                msb = crc[15] ^ sh[15];
                crc = {crc[14:0], 1'b0} ^ (msb ? poly : 16'h0000);
                sh  = {sh[14:0], 1'b0};
            end
        endfunction

        // one accepted payload transaction
        function void note_payload(logic [7:0] data, logic last);
            int hdr_cnt;
            if (!in_frame) begin
                // frame opening: preamble, flag, header clamped to its maximum
                hdr_cnt = (header_len > HDR_MAX_BYTES) ? HDR_MAX_BYTES : int'(header_len);
                for (int k = 0; k < int'(preamble_len); k++) begin
                    push_beat(PREAMBLE_BYTE, 1'b0);
                end
                push_beat(FLAG_BYTE, 1'b0);
                for (int k = 0; k < hdr_cnt; k++) begin
                    push_beat(hdr_value[(HDR_MAX_BYTES-1-k)*8 +: 8], 1'b0);
                end
                crc      = CRC_INIT;
                in_frame = 1'b1;
            end
            push_beat(data, 1'b0);
            fold_char(ascii_hex(data[7:4]));
            fold_char(ascii_hex(data[3:0]));
            if (last) begin
                push_beat(crc[15:8], 1'b0);
                push_beat(crc[7:0], 1'b0);
                push_beat(FLAG_BYTE, 1'b0);
                push_beat(FLAG_BYTE, 1'b1);
                in_frame = 1'b0;
                crc      = CRC_INIT;
            end
            expected_beats[expected_beats.size()-1].run_last = 1'b1;
        endfunction

        // one accepted frame transaction against the oldest expectation
        function void check_frame_byte(logic [7:0] fb, logic rl, logic fe);
            t_frame_beat want;
            if (expected_beats.size() == 0) begin
                errors++;
                $error("unexpected frame byte %02h (tlast %b, tuser %b)", fb, rl, fe);
            end else begin
                want = expected_beats.pop_front();
                if (fb !== want.frame_byte) begin
                    errors++;
                    $error("frame_byte: expected %02h, got %02h", want.frame_byte, fb);
                end
                if (rl !== want.run_last) begin
                    errors++;
                    $error("run_last: expected %b, got %b", want.run_last, rl);
                end
                if (fe !== want.frame_end) begin
                    errors++;
                    $error("frame_end: expected %b, got %b", want.frame_end, fe);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] data_byte
    logic        i_s_axis_tlast;   // last_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;   // [7:0] frame_byte
    logic        o_m_axis_tlast;   // run_last
    logic [0:0]  o_m_axis_tuser;   // [0] frame_end
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    t_frame_scoreboard sb;

    // idle percentages per phase, zero gives full-rate stretches
    int src_idle_pct;
    int sink_idle_pct;
    // long receiver hold requested by the stimulus, taken up by the sink process
    int sink_hold;
    int items_sent;
    longint cycle_count = 0;

    packet_framer_ascii_crc16_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    // apb write: setup cycle, then access cycle; register taken at the access edge
    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // offer one payload byte and wait for its transaction
    task automatic send_payload(input logic [7:0] data, input logic last);
        int gap;
        gap = ($urandom_range(0, 99) < src_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_payload(data, last);
        items_sent++;
    endtask

    // sender pause: drop valid right after the last transaction, wait for every frame byte
    task automatic wait_frames_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random register value, extremes now and then; upper junk bits included
    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // frame side: checks each transaction and drives tready with random stalls
    initial begin : frame_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_frame_byte(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]);
            end
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else if (stall == 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int pkt_left;
        int phase_len;

        sb              = new();
        items_sent      = 0;
        sink_hold       = 0;
        src_idle_pct    = 30;
        sink_idle_pct   = 30;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 5'd0;
        pwdata          = 64'd0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: single-byte packet, then digit/letter boundaries and 0xff
        send_payload(8'h00, 1'b1);
        send_payload(8'h09, 1'b0);
        send_payload(8'h0A, 1'b0);
        send_payload(8'hFF, 1'b1);
        wait_frames_drained();

        // zero polynomial, no preamble, no header
        cfg_write(REG_POLY, 64'd0);
        cfg_write(REG_PRE_CNT, 64'hFFFF_FFFF_FFFF_FFF0);
        cfg_write(REG_HDR_VAL, 64'd0);
        cfg_write(REG_HDR_LEN, 64'd0);
        send_payload(8'hA5, 1'b1);
        send_payload(8'h5A, 1'b0);
        send_payload(8'h3C, 1'b1);
        wait_frames_drained();

        // every register at its top value, header length 7 clamps to the maximum
        cfg_write(REG_POLY, {64{1'b1}});
        cfg_write(REG_PRE_CNT, {64{1'b1}});
        cfg_write(REG_HDR_VAL, {64{1'b1}});
        cfg_write(REG_HDR_LEN, {64{1'b1}});
        send_payload(8'hF0, 1'b0);
        send_payload(8'h0F, 1'b1);
        wait_frames_drained();

        // header length 6 also clamps; payload bytes equal to flag and preamble
        cfg_write(REG_POLY, 64'h0000_0000_0000_8005);
        cfg_write(REG_PRE_CNT, 64'h0000_0000_0000_0001);
        cfg_write(REG_HDR_VAL, 64'hA5A5_A501_2345_6789);
        cfg_write(REG_HDR_LEN, 64'hFFFF_FFFF_FFFF_FFFE);
        send_payload(8'h80, 1'b0);
        send_payload(8'h01, 1'b0);
        send_payload(8'h7E, 1'b0);
        send_payload(8'h55, 1'b1);
        wait_frames_drained();

        // register change in the middle of a frame
        send_payload(8'h12, 1'b0);
        wait_frames_drained();
        cfg_write(REG_POLY, 64'h1021);
        cfg_write(REG_PRE_CNT, 64'd3);
        cfg_write(REG_HDR_LEN, 64'd2);
        send_payload(8'h34, 1'b1);
        wait_frames_drained();

        // random part: packets of random length, phases may end mid-packet
        items_sent = 0;
        pkt_left   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            for (int r = 0; r < 4; r++) begin
                if ($urandom_range(0, 2) == 0) begin
                    cfg_write(2'(r), pick_reg_value());
                end
            end
            src_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            sink_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            phase_len     = $urandom_range(8, 40);
            // long receiver hold in the first phase and in some later ones,
            // the sender keeps offering so the input side backs up
            if (items_sent == 0 || $urandom_range(0, 9) == 0) begin
                src_idle_pct = 0;
                sink_hold    = LONG_HOLD;
            end
            for (int k = 0; k < phase_len; k++) begin
                if (pkt_left == 0) begin
                    pkt_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                            : $urandom_range(1, 6);
                end
                send_payload(8'($urandom), pkt_left == 1);
                pkt_left--;
            end
            wait_frames_drained();
        end

        // end of run: nothing expected, then a short quiet tail for stray output
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
